>>> rtl/core/tank_level_plant_emulator_macros.svh
// ----------------------------------------------------------------------------
// Tank level plant emulator assertion macros
// Shared property wrappers for the port checker; clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TANK_LEVEL_PLANT_EMULATOR_MACROS_SVH
`define TANK_LEVEL_PLANT_EMULATOR_MACROS_SVH

// same-cycle implication
`define TLPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tlpe_pkg.sv
// ----------------------------------------------------------------------------
// Tank level plant emulator package
// Shared types, register map and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlpe_pkg;

  // field widths
  localparam int DRIVE_W  = 12;
  localparam int LEVEL_W  = 29;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  // square root unit: 64-bit radicand, 32-bit root, one root bit per cycle
  localparam int SQ_RAD_W  = 64;
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W);

  // 0.1001 m in Q0.32, level saturation point
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 29'd429926226;

  // floor(n*2 cm * 2^32) for n = 1..5
  localparam int NUM_BANDS = 5;
  localparam logic [LEVEL_W-1:0] BAND_TOP [NUM_BANDS] = '{
    29'd85899345, 29'd171798691, 29'd257698037, 29'd343597383, 29'd429496729
  };

  typedef enum logic [2:0] {
    REG_NOISE_OFS  = 3'd0,
    REG_DEAD_ZONE  = 3'd1,
    REG_MAX_DRIVE  = 3'd2,
    REG_OUT_COEF   = 3'd3,
    REG_IN_PER_CODE = 3'd4,
    REG_LOW_BORDER = 3'd5,
    REG_LEVEL_GAIN = 3'd6,
    REG_FLOW_GAIN  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [11:0]        noise_ofs;
    logic [11:0]        dead_zone;
    logic [11:0]        max_drive;
    logic [23:0]        outflow_coef;
    logic [31:0]        inflow_per_code;
    logic [LEVEL_W-1:0] low_border;
    logic [15:0]        level_gain;
    logic [23:0]        flow_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    noise_ofs:       12'd95,
    dead_zone:       12'd1188,
    max_drive:       12'd3960,
    outflow_coef:    24'd65536,
    inflow_per_code: 32'd4096,
    low_border:      29'd4294967,
    level_gain:      16'd40509,
    flow_gain:       24'd3282944
  };

  typedef struct packed {
    logic                start;
    logic [SQ_RAD_W-1:0] radicand;
  } sq_req_t;

  typedef struct packed {
    logic                 done;
    logic [SQ_ROOT_W-1:0] root;
  } sq_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/tlpe_sqrt.sv
// ----------------------------------------------------------------------------
// Tank level plant emulator square root unit
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlpe_sqrt (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire tlpe_pkg::sq_req_t req_i,
  output tlpe_pkg::sq_rsp_t      rsp_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [tlpe_pkg::SQ_CNT_W-1:0]  cnt_q;
  logic [tlpe_pkg::SQ_RAD_W-1:0]  rad_q;
  logic [tlpe_pkg::SQ_REM_W-1:0]  rem_q, rem_d;
  logic [tlpe_pkg::SQ_ROOT_W-1:0] root_q;

  logic [tlpe_pkg::SQ_REM_W+1:0]  rem_sh;
  logic [tlpe_pkg::SQ_REM_W+1:0]  trial;
  logic                           fits;

  // bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    rem_sh = {rem_q, rad_q[tlpe_pkg::SQ_RAD_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    fits   = (rem_sh >= trial);
    rem_d  = fits ? tlpe_pkg::SQ_REM_W'(rem_sh - trial)
                  : tlpe_pkg::SQ_REM_W'(rem_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tlpe_pkg::SQ_CNT_W'(tlpe_pkg::SQ_ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[tlpe_pkg::SQ_RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[tlpe_pkg::SQ_ROOT_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

`default_nettype wire

>>> rtl/core/tlpe_cfg.sv
// ----------------------------------------------------------------------------
// Tank level plant emulator configuration registers
// APB register file, no wait states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlpe_cfg (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [tlpe_pkg::PADDR_W-1:0]     paddr,
  input  wire  [tlpe_pkg::PDATA_W-1:0]     pwdata,
  output logic [tlpe_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output tlpe_pkg::cfg_t                   cfg_o
);

  tlpe_pkg::cfg_t     cfg_q;
  tlpe_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = tlpe_pkg::reg_idx_e'(paddr[tlpe_pkg::PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tlpe_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        tlpe_pkg::REG_NOISE_OFS:   cfg_q.noise_ofs       <= pwdata[11:0];
        tlpe_pkg::REG_DEAD_ZONE:   cfg_q.dead_zone       <= pwdata[11:0];
        tlpe_pkg::REG_MAX_DRIVE:   cfg_q.max_drive       <= pwdata[11:0];
        tlpe_pkg::REG_OUT_COEF:    cfg_q.outflow_coef    <= pwdata[23:0];
        tlpe_pkg::REG_IN_PER_CODE: cfg_q.inflow_per_code <= pwdata;
        tlpe_pkg::REG_LOW_BORDER:  cfg_q.low_border      <= pwdata[tlpe_pkg::LEVEL_W-1:0];
        tlpe_pkg::REG_LEVEL_GAIN:  cfg_q.level_gain      <= pwdata[15:0];
        tlpe_pkg::REG_FLOW_GAIN:   cfg_q.flow_gain       <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tlpe_pkg::REG_NOISE_OFS:   prdata = tlpe_pkg::PDATA_W'(cfg_q.noise_ofs);
      tlpe_pkg::REG_DEAD_ZONE:   prdata = tlpe_pkg::PDATA_W'(cfg_q.dead_zone);
      tlpe_pkg::REG_MAX_DRIVE:   prdata = tlpe_pkg::PDATA_W'(cfg_q.max_drive);
      tlpe_pkg::REG_OUT_COEF:    prdata = tlpe_pkg::PDATA_W'(cfg_q.outflow_coef);
      tlpe_pkg::REG_IN_PER_CODE: prdata = cfg_q.inflow_per_code;
      tlpe_pkg::REG_LOW_BORDER:  prdata = tlpe_pkg::PDATA_W'(cfg_q.low_border);
      tlpe_pkg::REG_LEVEL_GAIN:  prdata = tlpe_pkg::PDATA_W'(cfg_q.level_gain);
      tlpe_pkg::REG_FLOW_GAIN:   prdata = tlpe_pkg::PDATA_W'(cfg_q.flow_gain);
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/tank_level_plant_emulator.sv
// ----------------------------------------------------------------------------
// Tank level plant emulator
// Single-tank Torricelli level model with pump dead zone and DAC outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one pump ADC code per sample tick.
//   Output channel (out_valid_o/out_ready_i): one result per input: level and
//   outflow DAC codes, clamped level, pump drive, limit flag, LED bar, alarm.
//   APB port: eight 32-bit registers at byte address 4*index; write them only
//   while the block is idle. pready is tied high.
//   Sequencing: two 32-step square roots run on the shared root unit, with
//   the multiply, add and clamp steps around them. One item is in work at
//   a time: a new input is accepted only while the sequencer is idle.
//   Reset: level and previous drive go to zero (empty tank), registers to
//   their defaults, both channels idle.
//   Stall: a finished result sits in the output register; the next input is
//   accepted meanwhile. If the following result completes before the stalled
//   one is taken, the sequencer waits in its last step until the slot frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tank_level_plant_emulator #(
  parameter int ADC_BITS = 12,
  parameter int DAC_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input channel
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [ADC_BITS-1:0]              adc_code_i,
  // output channel
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [DAC_BITS-1:0]              level_dac_o,
  output logic [DAC_BITS-1:0]              flow_dac_o,
  output logic [tlpe_pkg::LEVEL_W-1:0]     level_value_o,
  output logic [tlpe_pkg::DRIVE_W-1:0]     pump_drive_o,
  output logic                             drive_limited_o,
  output logic [tlpe_pkg::NUM_BANDS-1:0]   led_bar_o,
  output logic                             overflow_alarm_o,
  // APB configuration
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [tlpe_pkg::PADDR_W-1:0]     paddr,
  input  wire  [tlpe_pkg::PDATA_W-1:0]     pwdata,
  output logic [tlpe_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int CodeW = (ADC_BITS > 12) ? ADC_BITS : 12;
  localparam logic [DAC_BITS-1:0] DacTop = DAC_BITS'((2 ** DAC_BITS) - 41);
  localparam int SumW = 45;  // level + inflow, up to 2^45

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT1,    // sqrt(h) running
    S_MUL_OUT,  // outflow term in multiplier
    S_MUL_IN,   // inflow term in multiplier
    S_CLAMP,    // clamp new level, level DAC product
    S_LVL,      // level DAC code, start sqrt(h')
    S_ROOT2,    // sqrt(h') running
    S_FLOW,     // flow DAC code
    S_OUT       // hand result to the output register
  } state_e;

  state_e state_q;

  tlpe_pkg::cfg_t  cfg;
  tlpe_pkg::sq_req_t sq_req;
  tlpe_pkg::sq_rsp_t sq_rsp;

  // ---------------------------------------------------------------------------
  // Configuration registers and the shared root unit
  // ---------------------------------------------------------------------------
  tlpe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlpe_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  // ---------------------------------------------------------------------------
  // Plant state and working registers
  // ---------------------------------------------------------------------------
  logic [tlpe_pkg::LEVEL_W-1:0] tank_level_q;     // h, Q0.32
  logic [tlpe_pkg::DRIVE_W-1:0] prev_drive_q;     // u of last tick
  logic [tlpe_pkg::DRIVE_W-1:0] drive_q;          // u of this tick
  logic                         limited_q;
  logic [31:0]                  outterm_q;
  logic [SumW-1:0]              hn_q;
  logic                         neg_q;
  logic [63:0]                  mul_q;
  logic [DAC_BITS-1:0]          res_level_dac_q;
  logic [DAC_BITS-1:0]          res_flow_dac_q;

  logic in_xfer;
  logic out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_o || out_ready_i);

  // ---------------------------------------------------------------------------
  // Pump drive: noise offset, dead zone, upper limit
  // ---------------------------------------------------------------------------
  logic [CodeW-1:0] code_ext, ofs_ext, dz_ext, max_ext, t_val, drive_full;
  logic             drive_lim;

  always_comb begin
    code_ext = CodeW'(adc_code_i);
    ofs_ext  = CodeW'(cfg.noise_ofs);
    dz_ext   = CodeW'(cfg.dead_zone);
    max_ext  = CodeW'(cfg.max_drive);
    t_val    = (code_ext >= ofs_ext) ? (code_ext - ofs_ext) : '0;
    drive_lim = 1'b0;
    priority if (t_val < dz_ext) begin
      drive_full = '0;
    end else if (t_val > max_ext) begin
      drive_full = (max_ext > dz_ext) ? (max_ext - dz_ext) : '0;
      drive_lim  = 1'b1;
    end else begin
      drive_full = t_val - dz_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared 32x32 multiplier, operands picked by the sequencer step
  // ---------------------------------------------------------------------------
  logic [31:0] mul_a, mul_b;
  logic [tlpe_pkg::LEVEL_W-1:0] level_clamp;

  always_comb begin
    unique case (state_q)
      S_ROOT1: begin
        mul_a = sq_rsp.root;
        mul_b = 32'(cfg.outflow_coef);
      end
      S_MUL_OUT: begin
        mul_a = cfg.inflow_per_code;
        mul_b = 32'(prev_drive_q);
      end
      S_CLAMP: begin
        mul_a = 32'(level_clamp);
        mul_b = 32'(cfg.level_gain);
      end
      S_ROOT2: begin
        mul_a = sq_rsp.root;
        mul_b = 32'(cfg.flow_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Level update and clamp
  // ---------------------------------------------------------------------------
  logic [SumW-1:0] level_sum;
  logic            level_neg;
  logic [SumW-1:0] level_new;

  always_comb begin
    level_sum = SumW'(tank_level_q) + SumW'(mul_q[43:0]);
    level_neg = (level_sum < SumW'(outterm_q));
    level_new = level_sum - SumW'(outterm_q);
  end

  // negative, or falling below the low border -> empty; overfull saturates
  always_comb begin
    priority if (neg_q || ((hn_q < SumW'(tank_level_q)) &&
                           (hn_q < SumW'(cfg.low_border)))) begin
      level_clamp = '0;
    end else if (hn_q > SumW'(tlpe_pkg::LEVEL_HIGH)) begin
      level_clamp = tlpe_pkg::LEVEL_HIGH;
    end else begin
      level_clamp = hn_q[tlpe_pkg::LEVEL_W-1:0];
    end
  end

  // root requests: sqrt(h * 2^32) on accept, sqrt(h' * 2^18) of the unclamped h' after clamp
  always_comb begin
    sq_req.start    = 1'b0;
    sq_req.radicand = '0;
    if (in_xfer) begin
      sq_req.start    = 1'b1;
      sq_req.radicand = {3'b000, tank_level_q, 32'd0};
    end else if (state_q == S_LVL) begin
      sq_req.start    = 1'b1;
      sq_req.radicand = neg_q ? '0 : tlpe_pkg::SQ_RAD_W'({hn_q, 18'd0});
    end
  end

  // ---------------------------------------------------------------------------
  // DAC codes: round half up, saturate at full scale minus 40
  // ---------------------------------------------------------------------------
  logic [63:0] level_rnd, flow_rnd;
  logic [31:0] level_raw;
  logic [30:0] flow_raw;
  logic [DAC_BITS-1:0] level_code, flow_code;

  always_comb begin
    level_rnd  = mul_q + (64'd1 << 31);
    flow_rnd   = mul_q + (64'd1 << 32);
    level_raw  = level_rnd[63:32];
    flow_raw   = flow_rnd[63:33];
    level_code = (level_raw > 32'(DacTop)) ? DacTop : level_raw[DAC_BITS-1:0];
    flow_code  = (flow_raw > 31'(DacTop)) ? DacTop : flow_raw[DAC_BITS-1:0];
  end

  // ---------------------------------------------------------------------------
  // LED bar and alarm from the clamped level
  // ---------------------------------------------------------------------------
  logic [tlpe_pkg::NUM_BANDS-1:0] bar;
  logic                           alarm;

  always_comb begin
    alarm = (tank_level_q > tlpe_pkg::BAND_TOP[tlpe_pkg::NUM_BANDS-1]);
    bar   = '0;
    if (!alarm && (tank_level_q != '0)) begin
      bar[0] = 1'b1;
      for (int i = 0; i < tlpe_pkg::NUM_BANDS - 1; i++) begin
        bar[i+1] = (tank_level_q > tlpe_pkg::BAND_TOP[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, plant state and output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_o  <= 1'b0;
      tank_level_q <= '0;
      prev_drive_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:    if (in_xfer) state_q <= S_ROOT1;
        S_ROOT1:   if (sq_rsp.done) state_q <= S_MUL_OUT;
        S_MUL_OUT: state_q <= S_MUL_IN;
        S_MUL_IN:  state_q <= S_CLAMP;
        S_CLAMP: begin
          tank_level_q <= level_clamp;
          state_q      <= S_LVL;
        end
        S_LVL:     state_q <= S_ROOT2;
        S_ROOT2:   if (sq_rsp.done) state_q <= S_FLOW;
        S_FLOW: begin
          prev_drive_q <= drive_q;
          state_q      <= S_OUT;
        end
        S_OUT:     if (out_load) state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (in_xfer) begin
      drive_q   <= drive_full[tlpe_pkg::DRIVE_W-1:0];
      limited_q <= drive_lim;
    end
    if (state_q == S_MUL_OUT) begin
      outterm_q <= mul_q[55:24];
    end
    if (state_q == S_MUL_IN) begin
      hn_q  <= level_new;
      neg_q <= level_neg;
    end
    if (state_q == S_LVL) begin
      res_level_dac_q <= level_code;
    end
    if (state_q == S_FLOW) begin
      res_flow_dac_q <= flow_code;
    end
    if (out_load) begin
      level_dac_o      <= res_level_dac_q;
      flow_dac_o       <= res_flow_dac_q;
      level_value_o    <= tank_level_q;
      pump_drive_o     <= drive_q;
      drive_limited_o  <= limited_q;
      led_bar_o        <= bar;
      overflow_alarm_o <= alarm;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tlpe_checker.sv
// ----------------------------------------------------------------------------
// Tank level plant emulator port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tank_level_plant_emulator_macros.svh"

module tlpe_checker #(
  parameter int ADC_BITS = 12,
  parameter int DAC_BITS = 12
) (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_ready_o,
  input wire [ADC_BITS-1:0]             adc_code_i,
  input wire                            out_valid_o,
  input wire                            out_ready_i,
  input wire [DAC_BITS-1:0]             level_dac_o,
  input wire [DAC_BITS-1:0]             flow_dac_o,
  input wire [tlpe_pkg::LEVEL_W-1:0]    level_value_o,
  input wire [tlpe_pkg::NUM_BANDS-1:0]  led_bar_o,
  input wire                            overflow_alarm_o
);

  localparam logic [DAC_BITS-1:0] DacTop = DAC_BITS'((2 ** DAC_BITS) - 41);

  logic [tlpe_pkg::NUM_BANDS-1:0] bar_inc;
  logic                           adc_seen;

  assign bar_inc  = led_bar_o + 1'b1;
  assign adc_seen = (adc_code_i == adc_code_i);

  // a stalled result holds
  `TLPE_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(level_dac_o) && $stable(flow_dac_o) && $stable(level_value_o), "stalled result changed")

  // one item in work at a time
  `TLPE_ASSERT_NXT(a_busy_after_xfer, in_valid_i && in_ready_o && adc_seen, !in_ready_o, "input taken while busy")

  // DAC codes and level stay inside their saturation limits
  `TLPE_ASSERT_NOW(a_out_range, out_valid_o, (level_dac_o <= DacTop) && (flow_dac_o <= DacTop) && (level_value_o <= tlpe_pkg::LEVEL_HIGH), "result out of range")

  // thermometer bar, dark under alarm
  `TLPE_ASSERT_NOW(a_bar_code, out_valid_o, ((led_bar_o & bar_inc) == '0) && (!overflow_alarm_o || (led_bar_o == '0)), "bad LED bar code")

endmodule

bind tank_level_plant_emulator tlpe_checker #(
  .ADC_BITS (ADC_BITS),
  .DAC_BITS (DAC_BITS)
) u_tlpe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .adc_code_i       (adc_code_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .level_dac_o      (level_dac_o),
  .flow_dac_o       (flow_dac_o),
  .level_value_o    (level_value_o),
  .led_bar_o        (led_bar_o),
  .overflow_alarm_o (overflow_alarm_o)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank level plant emulator testbench
// Drives pump ADC samples through the valid/ready input channel and compares
// every output transfer, field by field, with a cycle-free model of the tank
// kept in this file. Register settings are changed over the APB port between
// phases, with read-back. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tlpe_pkg::*;

  // full-scale DAC code: 2^12 - 1 minus the 40-code headroom
  localparam int DAC_TOP_CODE  = (1 << 12) - 1 - 40;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 100;      // quiet stretch after the final drain
  localparam int RUN_LIMIT     = 2_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_REGS      = 8;
  localparam int SWEEP_PHASES  = 6;
  localparam int SWEEP_SAMPLES = 275;

  // reset-time pump thresholds, used to aim the directed samples
  localparam logic [11:0] OFS0 = CFG_RESET.noise_ofs;
  localparam logic [11:0] DZ0  = CFG_RESET.dead_zone;
  localparam logic [11:0] MX0  = CFG_RESET.max_drive;

  // one result transfer as the output ports present it
  typedef struct packed {
    logic [11:0]          level_dac;
    logic [11:0]          flow_dac;
    logic [LEVEL_W-1:0]   level_value;
    logic [DRIVE_W-1:0]   pump_drive;
    logic                 drive_limited;
    logic [NUM_BANDS-1:0] led_bar;
    logic                 overflow_alarm;
  } tank_reading_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [11:0]          adc_code_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [11:0]          level_dac_o;
  logic [11:0]          flow_dac_o;
  logic [LEVEL_W-1:0]   level_value_o;
  logic [DRIVE_W-1:0]   pump_drive_o;
  logic                 drive_limited_o;
  logic [NUM_BANDS-1:0] led_bar_o;
  logic                 overflow_alarm_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PADDR_W-1:0]   paddr       = '0;
  logic [PDATA_W-1:0]   pwdata      = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // --------------------------------------------------------------------------
  // Tank model state: settings, level and last drive, plus expected readings
  // --------------------------------------------------------------------------
  cfg_t               plant_cfg = CFG_RESET;
  logic [31:0]        tank_h    = '0;
  logic [DRIVE_W-1:0] last_drive = '0;
  tank_reading_t      pending_readings [$];

  int     samples_sent     = 0;
  int     readings_checked = 0;
  int     settings_used    = 0;
  int     fail_count       = 0;
  int     limited_seen     = 0;
  int     alarm_seen       = 0;
  int     full_seen        = 0;
  int     drained_seen     = 0;   // level went negative, taken as empty
  int     snap_seen        = 0;   // falling level snapped to zero at low border
  longint cycle_count      = 0;

  bit          steady_flow = 1'b0;  // when set neither side idles
  int          stall_left  = 0;
  int          burst_left  = 0;
  logic [11:0] burst_code  = '0;

  tank_level_plant_emulator u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .adc_code_i       (adc_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .level_dac_o      (level_dac_o),
    .flow_dac_o       (flow_dac_o),
    .level_value_o    (level_value_o),
    .pump_drive_o     (pump_drive_o),
    .drive_limited_o  (drive_limited_o),
    .led_bar_o        (led_bar_o),
    .overflow_alarm_o (overflow_alarm_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Run limit: a correct run is far shorter, so hitting this means a hang
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles, %0d readings still pending", cycle_count,
             pending_readings.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tank arithmetic
  // --------------------------------------------------------------------------

  // floor of the square root, built one root bit at a time from the top
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r[31:0];
  endfunction

  // One sample tick: derives the pump drive, steps the level with the drive
  // of the previous tick, and forms every output field.
  task automatic advance_tank(input logic [11:0] code, output tank_reading_t rd);
    logic [11:0] trimmed, drv;
    logic        lim, sink;
    logic [63:0] h, out_term, in_term, hn, rt, lvl, flw;

    // noise offset, then dead zone and drive ceiling
    trimmed = (code >= plant_cfg.noise_ofs) ? code - plant_cfg.noise_ofs : 12'd0;
    lim = 1'b0;
    if (trimmed < plant_cfg.dead_zone) begin
      drv = '0;
    end else if (trimmed > plant_cfg.max_drive) begin
      drv = (plant_cfg.max_drive > plant_cfg.dead_zone) ?
            plant_cfg.max_drive - plant_cfg.dead_zone : 12'd0;
      lim = 1'b1;
    end else begin
      drv = trimmed - plant_cfg.dead_zone;
    end

    // h' = h - coef*sqrt(h) + inflow*u_prev; sqrt(h) in Q0.32, coef in Q0.24
    h        = 64'(tank_h);
    out_term = (64'(plant_cfg.outflow_coef) * 64'(floor_sqrt(h << 32))) >> 24;
    in_term  = 64'(plant_cfg.inflow_per_code) * 64'(last_drive);
    sink     = (h + in_term) < out_term;
    hn       = sink ? 64'd0 : h + in_term - out_term;

    // outflow DAC follows the unclamped level: Q.25 root times Q16.8 gain
    rt  = sink ? 64'd0 : 64'(floor_sqrt(hn << 18));
    flw = (rt * 64'(plant_cfg.flow_gain) + (64'd1 << 32)) >> 33;
    if (flw > DAC_TOP_CODE) flw = DAC_TOP_CODE;

    if (sink) begin
      hn = '0;
      drained_seen++;
    end else if (hn < h && hn < 64'(plant_cfg.low_border)) begin
      if (hn != 0) snap_seen++;
      hn = '0;
    end else if (hn > 64'(LEVEL_HIGH)) begin
      hn = 64'(LEVEL_HIGH);
      full_seen++;
    end
    tank_h     = hn[31:0];
    last_drive = drv;

    lvl = (hn * 64'(plant_cfg.level_gain) + (64'd1 << 31)) >> 32;
    if (lvl > DAC_TOP_CODE) lvl = DAC_TOP_CODE;

    rd.level_dac      = lvl[11:0];
    rd.flow_dac       = flw[11:0];
    rd.level_value    = hn[LEVEL_W-1:0];
    rd.pump_drive     = drv;
    rd.drive_limited  = lim;
    rd.led_bar        = '0;
    rd.overflow_alarm = 1'b0;
    // above the top band the alarm is on and the bar goes dark
    if (hn > 64'(BAND_TOP[NUM_BANDS-1])) begin
      rd.overflow_alarm = 1'b1;
      alarm_seen++;
    end else if (hn != 0) begin
      rd.led_bar[0] = 1'b1;
      for (int i = 0; i < NUM_BANDS - 1; i++)
        if (hn > 64'(BAND_TOP[i])) rd.led_bar[i+1] = 1'b1;
    end
    if (lim) limited_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Error log: first few in detail, the rest only counted
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, mostly short, now and then long
  // --------------------------------------------------------------------------
  initial begin : sink_pacing
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!steady_flow && $urandom_range(99) < 20) begin
        out_ready_i <= 1'b0;
        if ($urandom_range(99) < 1) stall_left = $urandom_range(150, 10);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every output transfer is checked against the oldest expected reading.
  // Values are read just after the edge, before the design's own updates land.
  always @(posedge clk_i) begin : reading_check
    tank_reading_t got, want;
    string         bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.level_dac      = level_dac_o;
      got.flow_dac       = flow_dac_o;
      got.level_value    = level_value_o;
      got.pump_drive     = pump_drive_o;
      got.drive_limited  = drive_limited_o;
      got.led_bar        = led_bar_o;
      got.overflow_alarm = overflow_alarm_o;
      if (pending_readings.size() == 0) begin
        note_mismatch($sformatf("result transfer with nothing expected, level=%0d",
                                got.level_value));
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        bad = "";
        if (got.level_dac !== want.level_dac)           bad = {bad, " level_dac"};
        if (got.flow_dac !== want.flow_dac)             bad = {bad, " flow_dac"};
        if (got.level_value !== want.level_value)       bad = {bad, " level_value"};
        if (got.pump_drive !== want.pump_drive)         bad = {bad, " pump_drive"};
        if (got.drive_limited !== want.drive_limited)   bad = {bad, " drive_limited"};
        if (got.led_bar !== want.led_bar)               bad = {bad, " led_bar"};
        if (got.overflow_alarm !== want.overflow_alarm) bad = {bad, " overflow_alarm"};
        if (bad != "")
          note_mismatch($sformatf(
            "reading %0d,%s: exp %0d %0d %0d %0d %0b %b %0b, got %0d %0d %0d %0d %0b %b %0b",
            readings_checked, bad,
            want.level_dac, want.flow_dac, want.level_value, want.pump_drive,
            want.drive_limited, want.led_bar, want.overflow_alarm,
            got.level_dac, got.flow_dac, got.level_value, got.pump_drive,
            got.drive_limited, got.led_bar, got.overflow_alarm));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Presents one ADC sample and returns at the edge of its transfer. valid is
  // left high so a back-to-back sample needs no second assignment; it drops
  // only when a gap is taken or the input goes quiet.
  task automatic send_code(input logic [11:0] code);
    tank_reading_t rd;
    int            gap;
    if (!steady_flow) begin
      gap = 0;
      while ($urandom_range(99) < 20) gap++;
      if ($urandom_range(99) < 3) gap += $urandom_range(100, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    adc_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    advance_tank(code, rd);
    pending_readings.push_back(rd);
    samples_sent++;
  endtask

  // Input goes quiet, then wait for every expected reading to come out.
  task automatic wait_readings_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [11:0] clamp_code(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return 12'(v);
  endfunction

  // Pump samples mostly come in bursts around one operating point, aimed at
  // the noise, dead-zone and ceiling thresholds of the current setting, so
  // the tank really fills and drains; the rest is uniform noise.
  function automatic logic [11:0] pump_sample();
    int base;
    if ($urandom_range(99) < 15) return 12'($urandom_range(4095));
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      case ($urandom_range(4))
        0: base = $urandom_range(4095);
        1: base = int'(plant_cfg.noise_ofs) + int'(plant_cfg.dead_zone)
                  + int'($urandom_range(6)) - 3;
        2: base = int'(plant_cfg.noise_ofs) + int'(plant_cfg.max_drive)
                  + int'($urandom_range(6)) - 3;
        3: base = $urandom_range(1) ? 4095 : 0;
        default: base = int'(plant_cfg.noise_ofs) + int'($urandom_range(6)) - 3;
      endcase
      burst_code = clamp_code(base);
    end
    burst_left--;
    return clamp_code(int'(burst_code) + int'($urandom_range(4)) - 2);
  endfunction

  // --------------------------------------------------------------------------
  // Register access
  // --------------------------------------------------------------------------
  function automatic logic [31:0] reg_field(input cfg_t c, input reg_idx_e idx);
    case (idx)
      REG_NOISE_OFS:   return 32'(c.noise_ofs);
      REG_DEAD_ZONE:   return 32'(c.dead_zone);
      REG_MAX_DRIVE:   return 32'(c.max_drive);
      REG_OUT_COEF:    return 32'(c.outflow_coef);
      REG_IN_PER_CODE: return c.inflow_per_code;
      REG_LOW_BORDER:  return 32'(c.low_border);
      REG_LEVEL_GAIN:  return 32'(c.level_gain);
      REG_FLOW_GAIN:   return 32'(c.flow_gain);
      default:         return '0;
    endcase
  endfunction

  // setup then access; psel stays up so writes can follow back to back
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // prdata is sampled mid access phase
  task automatic apb_read(input reg_idx_e idx, output logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    val = prdata;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic read_back_all(input cfg_t c);
    logic [31:0] got;
    reg_idx_e    idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_e'(i);
      apb_read(idx, got);
      if (got !== reg_field(c, idx))
        note_mismatch($sformatf("register %s read 0x%0h, expected 0x%0h",
                                idx.name(), got, reg_field(c, idx)));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // New setting only while idle: all readings out first.
  task automatic apply_config(input cfg_t c);
    reg_idx_e idx;
    wait_readings_drained();
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_e'(i);
      apb_write(idx, reg_field(c, idx));
    end
    plant_cfg = c;
    read_back_all(c);
    settings_used++;
  endtask

  // mostly values in the useful range, sometimes zero, all ones or anything
  function automatic logic [31:0] spread(input logic [31:0] top, input logic [31:0] usual);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return top;
    if (roll < 45) return $urandom_range(top);
    return $urandom_range(usual);
  endfunction

  function automatic cfg_t random_plant_cfg();
    cfg_t c;
    c.noise_ofs       = 12'(spread(32'd4095, 32'd300));
    c.dead_zone       = 12'(spread(32'd4095, 32'd2000));
    c.max_drive       = 12'(spread(32'd4095, 32'd4095));
    c.outflow_coef    = 24'(spread(32'hFF_FFFF, 32'd1 << 18));
    c.inflow_per_code = spread(32'hFFFF_FFFF, 32'd1 << 14);
    c.low_border      = LEVEL_W'(spread(32'h1FFF_FFFF, 32'd1 << 26));
    c.level_gain      = 16'(spread(32'hFFFF, 32'hFFFF));
    c.flow_gain       = 24'(spread(32'hFF_FFFF, 32'hFF_FFFF));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values read back, then samples on each threshold of the reset
  // setting: noise floor, dead-zone edge, drive ceiling and full scale.
  task automatic test_directed_edges();
    logic [11:0] edge_codes [12] = '{
      12'd0, OFS0 - 12'd1, OFS0, OFS0 + DZ0 - 12'd1, OFS0 + DZ0, OFS0 + DZ0 + 12'd1,
      OFS0 + MX0, OFS0 + MX0 + 12'd1, 12'd4095, 12'd2500, 12'd4095, 12'd0
    };
    read_back_all(CFG_RESET);
    foreach (edge_codes[i]) send_code(edge_codes[i]);
  endtask

  // Short scripted runs that force the level clamps.
  task automatic test_special_cases();
    cfg_t c;
    // strong inflow fills past full scale (alarm, bar dark); with a heavy
    // outflow and a high low border the first falling tick snaps to zero
    c = CFG_RESET;
    c.inflow_per_code = 32'd1 << 20;
    c.outflow_coef    = 24'd1 << 22;
    c.low_border      = LEVEL_W'(1) << 28;
    apply_config(c);
    send_code(12'd4095);
    send_code(12'd4095);
    send_code(12'd4095);
    send_code(12'd0);
    send_code(12'd0);
    send_code(12'd0);
    // near-unity outflow coefficient: a full tank with no inflow goes negative
    c = CFG_RESET;
    c.outflow_coef    = 24'hFF_FFFF;
    c.inflow_per_code = 32'd1 << 20;
    apply_config(c);
    send_code(12'd4095);
    send_code(12'd4095);
    send_code(12'd0);
    send_code(12'd0);
    send_code(12'd0);
    // maximum inflow and gains: level sum far beyond the 0.1001 m ceiling, both DACs saturate
    c = '1;
    c.noise_ofs = '0;
    c.dead_zone = '0;
    apply_config(c);
    send_code(12'd4095);
    send_code(12'd4095);
    send_code(12'd4095);
    send_code(12'd0);
  endtask

  // Every register at zero, then every register all ones.
  task automatic test_register_extremes();
    apply_config('0);
    repeat (25) send_code(pump_sample());
    apply_config('1);
    repeat (25) send_code(pump_sample());
  endtask

  // Bulk random run over several settings. One phase runs with no idling on
  // either side; in another the sender holds off until the block is empty.
  task automatic test_random_sweep();
    for (int p = 0; p < SWEEP_PHASES; p++) begin
      apply_config(p == 0 ? CFG_RESET : random_plant_cfg());
      steady_flow = (p == 2);
      for (int n = 0; n < SWEEP_SAMPLES; n++) begin
        if (p == 3 && n == SWEEP_SAMPLES / 2) wait_readings_drained();
        send_code(pump_sample());
      end
      steady_flow = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_special_cases();
    test_register_extremes();
    test_random_sweep();

    // everything out, then a quiet stretch to catch any stray transfer
    wait_readings_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d pump samples over %0d register settings, %0d readings compared",
             samples_sent, settings_used, readings_checked);
    $display("drive limited %0d, alarm %0d, held at full %0d, drained %0d, snapped low %0d",
             limited_seen, alarm_seen, full_seen, drained_seen, snap_seen);
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> tank_level_plant_emulator.f
+incdir+rtl/core
rtl/core/tlpe_pkg.sv
rtl/core/tlpe_sqrt.sv
rtl/core/tlpe_cfg.sv
rtl/core/tank_level_plant_emulator.sv
rtl/core/tlpe_checker.sv
tb/tb_top.sv
